FILE: src/pn2d_pkg.sv
// Package: shared constants, types and trig table function for the 2D noise block.
package pn2d_pkg;
   localparam int FracBits = 16;
   localparam int TrigBits = 10;
   localparam int QBits    = TrigBits - 2;
   localparam int TrigSize = 1 << TrigBits;
   localparam int QSize    = 1 << QBits;

   localparam logic [31:0] HashK1 = 32'd3284157443;
   localparam logic [31:0] HashK2 = 32'd1911520717;
   localparam logic [31:0] HashK3 = 32'd2048419325;

   localparam logic [63:0] PolyC1 = 64'd1686629713;
   localparam logic [63:0] PolyC3 = 64'd693598668;
   localparam logic [63:0] PolyC5 = 64'd85569306;
   localparam logic [63:0] PolyC7 = 64'd5026995;
   localparam logic [63:0] PolyC9 = 64'd172272;

   localparam logic [15:0] SeedReset = 16'd255;

   typedef logic signed [15:0] q15_type;
   typedef logic [15:0] qwave_type [QSize];

   // quarter-wave sine, only evaluated at elaboration to fill the constant table
   function automatic logic [15:0] quarter_sine(input logic [63:0] t);
      logic [63:0] t2;
      logic [63:0] acc;
      logic [63:0] v;
      t2  = (t * t) >> 16;
      acc = PolyC9;
      acc = PolyC7 - ((acc * t2) >> 16);
      acc = PolyC5 - ((acc * t2) >> 16);
      acc = PolyC3 - ((acc * t2) >> 16);
      acc = PolyC1 - ((acc * t2) >> 16);
      v   = (acc * t) >> 16;
      v   = (v + 64'd16384) >> 15;
      if (v > 64'd32767) v = 64'd32767;
      return v[15:0];
   endfunction

   function automatic qwave_type build_qwave();
      qwave_type tab;
      for (int i = 0; i < QSize; i++) tab[i] = quarter_sine(64'(i) << (16 - QBits));
      return tab;
   endfunction

   localparam qwave_type   QWave = build_qwave();
   // quarter-wave value at exactly a quarter turn
   localparam logic [15:0] QPeak = quarter_sine(64'(QSize) << (16 - QBits));

   function automatic q15_type table_sine(input logic [TrigBits-1:0] k);
      logic [1:0]     quad;
      logic [QBits:0] r;
      logic [15:0]    s;
      quad = k[TrigBits-1 -: 2];
      r    = {1'b0, k[QBits-1:0]};
      if (quad[0]) r = (QBits+1)'(1 << QBits) - r;
      s = r[QBits] ? QPeak : QWave[r[QBits-1:0]];
      return quad[1] ? -$signed(s) : $signed(s);
   endfunction

   typedef struct packed {
      logic signed [31:0] x0;
      logic signed [31:0] y0;
      logic [FracBits-1:0] fx;
      logic [FracBits-1:0] fy;
   } point_type;
endpackage

FILE: src/pn2d_if.sv
// Interfaces: valid/ready channels for points and noise words.
interface pn2d_req_if;
   import pn2d_pkg::*;
   logic        valid;
   logic        ready;
   logic [31:0] point_x;
   logic [31:0] point_y;
   modport source (output valid, point_x, point_y, input ready);
   modport sink   (input valid, point_x, point_y, output ready);
endinterface

interface pn2d_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] noise_value;
   modport source (output valid, noise_value, input ready);
   modport sink   (input valid, noise_value, output ready);
endinterface

FILE: src/pn2d_corner.sv
// One corner: hash, angle, gradient lookup and dot product, five register stages.
module pn2d_corner import pn2d_pkg::*; (
   input  logic                  clock,
   input  logic                  adv,
   input  logic [31:0]           cx,
   input  logic [31:0]           cy,
   input  logic signed [FracBits:0] dx,
   input  logic signed [FracBits:0] dy,
   input  logic [15:0]           seed,
   output logic signed [31:0]    dot
);
   // stage 1: a*K1
   logic [31:0] a1_ff, b1_ff;
   logic signed [FracBits:0] dx1_ff, dy1_ff, dx2_ff, dy2_ff, dx3_ff, dy3_ff,
                             dx4_ff, dy4_ff;
   // stage 2: b*K2
   logic [31:0] a2_ff, b2_ff;
   // stage 3: a*K3
   logic [31:0] a3_ff;
   // stage 4: angle
   logic [31:0] ang_ff;
   // stage 5: products
   logic signed [FracBits+16:0] pc_ff, ps_ff;
   logic signed [FracBits+17:0] sum;
   logic [31:0] b_x, a_x;
   logic [TrigBits-1:0] k, kc;

   assign b_x = b1_ff ^ {a1_ff[15:0], a1_ff[31:16]};
   assign a_x = a2_ff ^ {b2_ff[15:0], b2_ff[31:16]};
   assign k   = ang_ff[31 -: TrigBits];
   assign kc  = k + TrigBits'(1 << QBits);

   always_ff @(posedge clock) begin
      if (adv) begin
         a1_ff  <= 32'(cx * HashK1);
         b1_ff  <= cy;
         dx1_ff <= dx;  dy1_ff <= dy;
         a2_ff  <= a1_ff;
         b2_ff  <= 32'(b_x * HashK2);
         dx2_ff <= dx1_ff; dy2_ff <= dy1_ff;
         a3_ff  <= 32'(a_x * HashK3);
         dx3_ff <= dx2_ff; dy3_ff <= dy2_ff;
         ang_ff <= 32'(a3_ff * {16'd0, seed});
         dx4_ff <= dx3_ff; dy4_ff <= dy3_ff;
         pc_ff  <= dx4_ff * table_sine(kc);
         ps_ff  <= dy4_ff * table_sine(k);
      end
   end

   assign sum = {pc_ff[FracBits+16], pc_ff} + {ps_ff[FracBits+16], ps_ff};
   assign dot = 32'(sum >>> FracBits);
endmodule

FILE: src/pn2d_lerp.sv
// Registered linear interpolation n0 + floor((n1-n0)*w / 2^FracBits).
module pn2d_lerp import pn2d_pkg::*; (
   input  logic                clock,
   input  logic                adv,
   input  logic signed [31:0]  n0,
   input  logic signed [31:0]  n1,
   input  logic [FracBits-1:0] w,
   output logic signed [31:0]  res_ff
);
   logic signed [32:0] diff;
   logic signed [FracBits+33:0] prod;
   assign diff = {n0[31], n0} - {n1[31], n1};
   assign prod = (-diff) * $signed({1'b0, w});
   always_ff @(posedge clock) begin
      if (adv) res_ff <= n0 + 32'(prod >>> FracBits);
   end
endmodule

FILE: src/perlin_noise_2d.sv
// Top level: 2D gradient noise pipeline with output register.
// Pipeline: 8 register stages; the last one is the output register.
// Throughput: one point per cycle; the pipeline stalls as a whole when rsp backs up.
// Four corner units (hash multiplies, angle, table, dot) feed two interpolation stages.
// Reset: synchronous, clears valid bits and sets seed_ff to 255.
module perlin_noise_2d import pn2d_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   pn2d_req_if.sink    req,
   pn2d_rsp_if.source  rsp,
   input  logic        csr_we,
   input  logic [15:0] csr_wdata
);
   localparam int Depth = 8;
   logic [15:0] seed_ff;
   logic [Depth-1:0] vld_ff;
   logic adv;
   logic signed [31:0] x0, y0, d00, d10, d01, d11, ix0_ff, ix1_ff, v_ff;
   logic [FracBits-1:0] fx, fy;
   logic signed [FracBits:0] dx0, dx1, dy0, dy1;
   logic [FracBits-1:0] fx_ff [5], fy_ff [6];
   logic signed [31:0] sat;
   logic [15:0] out_ff;

   // the last stage is the output register; advance when it is free or taken
   assign adv = !vld_ff[Depth-1] || rsp.ready;
   assign req.ready = adv;
   assign rsp.valid = vld_ff[Depth-1];
   assign rsp.noise_value = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= SeedReset;
         vld_ff  <= '0;
      end else begin
         if (csr_we) seed_ff <= csr_wdata;
         if (adv) vld_ff <= {vld_ff[Depth-2:0], req.valid};
      end
   end

   assign x0  = $signed(req.point_x) >>> FracBits;
   assign y0  = $signed(req.point_y) >>> FracBits;
   assign fx  = req.point_x[FracBits-1:0];
   assign fy  = req.point_y[FracBits-1:0];
   assign dx0 = $signed({1'b0, fx});
   assign dy0 = $signed({1'b0, fy});
   assign dx1 = dx0 - $signed((FracBits+1)'(1 << FracBits));
   assign dy1 = dy0 - $signed((FracBits+1)'(1 << FracBits));

   always_ff @(posedge clock) begin
      if (adv) begin
         fx_ff[0] <= fx; fy_ff[0] <= fy;
         for (int i = 1; i < 5; i++) fx_ff[i] <= fx_ff[i-1];
         for (int i = 1; i < 6; i++) fy_ff[i] <= fy_ff[i-1];
      end
   end

   pn2d_corner u_c00 (.clock, .adv, .cx(x0),   .cy(y0),   .dx(dx0), .dy(dy0),
                      .seed(seed_ff), .dot(d00));
   pn2d_corner u_c10 (.clock, .adv, .cx(x0+1), .cy(y0),   .dx(dx1), .dy(dy0),
                      .seed(seed_ff), .dot(d10));
   pn2d_corner u_c01 (.clock, .adv, .cx(x0),   .cy(y0+1), .dx(dx0), .dy(dy1),
                      .seed(seed_ff), .dot(d01));
   pn2d_corner u_c11 (.clock, .adv, .cx(x0+1), .cy(y0+1), .dx(dx1), .dy(dy1),
                      .seed(seed_ff), .dot(d11));

   pn2d_lerp u_lx0 (.clock, .adv, .n0(d00), .n1(d10), .w(fx_ff[4]), .res_ff(ix0_ff));
   pn2d_lerp u_lx1 (.clock, .adv, .n0(d01), .n1(d11), .w(fx_ff[4]), .res_ff(ix1_ff));
   pn2d_lerp u_ly  (.clock, .adv, .n0(ix0_ff), .n1(ix1_ff), .w(fy_ff[5]), .res_ff(v_ff));

   assign sat = (v_ff > 32'sd32767) ? 32'sd32767 :
                (v_ff < -32'sd32768) ? -32'sd32768 : v_ff;

   always_ff @(posedge clock) begin
      if (adv) out_ff <= sat[15:0];
   end

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(out_ff))
      else $error("result lost under stall");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp.valid |-> req.ready)
      else $error("pipeline stalled with empty output");
   a_flow: assert property (@(posedge clock) disable iff (reset)
      req.valid && req.ready |=> vld_ff[0])
      else $error("accepted word not tracked");
endmodule

FILE: dv/tb_perlin_noise_2d_if.sv
// Testbench helper interface carrying the configuration port drive.
interface tb_pn2d_csr_if;
   logic        we;
   logic [15:0] wdata;
endinterface

FILE: dv/tb_perlin_noise_2d.sv
// Testbench for perlin_noise_2d: directed and random points checked against a noise predictor.
module tb_perlin_noise_2d import pn2d_pkg::*;;

   logic clock;
   logic reset;

   pn2d_req_if req ();
   pn2d_rsp_if rsp ();
   tb_pn2d_csr_if csr ();

   perlin_noise_2d dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req.sink),
      .rsp       (rsp.source),
      .csr_we    (csr.we),
      .csr_wdata (csr.wdata)
   );

   localparam int Latency   = 8;
   localparam int IdleLimit = 20000;

   logic [15:0] seed_model;
   logic [15:0] noise_queue[$];
   int          mismatches;
   int          words_checked;
   int          points_sent;
   int          idle_cycles;
   bit          stall_enable;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // --- predictor ---
   function automatic logic [31:0] rotl16(input logic [31:0] v);
      return {v[15:0], v[31:16]};
   endfunction

   function automatic logic [31:0] hash_corner(input logic [31:0] cx, input logic [31:0] cy);
      logic [31:0] a;
      logic [31:0] b;
      a = cx * HashK1;
      b = cy ^ rotl16(a);
      b = b * HashK2;
      a = a ^ rotl16(b);
      return a * HashK3;
   endfunction

   function automatic logic [15:0] quarter_wave(input longint unsigned t);
      longint unsigned t2;
      longint unsigned acc;
      longint unsigned v;
      t2  = (t * t) >> 16;
      acc = 172272;
      acc = 64'd5026995 - ((acc * t2) >> 16);
      acc = 64'd85569306 - ((acc * t2) >> 16);
      acc = 64'd693598668 - ((acc * t2) >> 16);
      acc = 64'd1686629713 - ((acc * t2) >> 16);
      v   = (acc * t) >> 16;
      v   = (v + 16384) >> 15;
      if (v > 32767) v = 32767;
      return v[15:0];
   endfunction

   function automatic longint sine_at(input int unsigned k);
      int unsigned quad;
      int unsigned r;
      longint      s;
      quad = (k >> QBits) & 3;
      r    = k & ((1 << QBits) - 1);
      if (quad[0]) r = (1 << QBits) - r;
      s = quarter_wave(longint'(r) << (16 - QBits));
      return quad[1] ? -s : s;
   endfunction

   function automatic longint gradient_dot(input logic [31:0] cx, input logic [31:0] cy,
                                           input longint dx, input longint dy);
      logic [31:0] ang;
      int unsigned k;
      ang = hash_corner(cx, cy) * {16'd0, seed_model};
      k   = ang >> (32 - TrigBits);
      return (dx * sine_at((k + (1 << QBits)) % TrigSize) + dy * sine_at(k)) >>> FracBits;
   endfunction

   function automatic logic [15:0] predict_noise(input logic [31:0] px, input logic [31:0] py);
      logic [31:0] x0;
      logic [31:0] y0;
      longint      fx;
      longint      fy;
      longint      one;
      longint      n00;
      longint      n10;
      longint      n01;
      longint      n11;
      longint      ix0;
      longint      ix1;
      longint      v;
      x0  = $signed(px) >>> FracBits;
      y0  = $signed(py) >>> FracBits;
      fx  = px[FracBits-1:0];
      fy  = py[FracBits-1:0];
      one = longint'(1) << FracBits;
      n00 = gradient_dot(x0, y0, fx, fy);
      n10 = gradient_dot(x0 + 1, y0, fx - one, fy);
      n01 = gradient_dot(x0, y0 + 1, fx, fy - one);
      n11 = gradient_dot(x0 + 1, y0 + 1, fx - one, fy - one);
      ix0 = n00 + (((n10 - n00) * fx) >>> FracBits);
      ix1 = n01 + (((n11 - n01) * fx) >>> FracBits);
      v   = ix0 + (((ix1 - ix0) * fy) >>> FracBits);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   function automatic int gap_length();
      if ($urandom_range(0, 2) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
      return $urandom_range(0, 3);
   endfunction

   // --- drivers ---
   // valid stays high after an accept so back-to-back words need only one drive per edge
   task automatic send_point(input logic [31:0] px, input logic [31:0] py, input bit idle);
      int gap;
      gap = idle ? gap_length() : 0;
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid   <= 1'b1;
      req.point_x <= px;
      req.point_y <= py;
      noise_queue.push_back(predict_noise(px, py));
      do @(posedge clock); while (!req.ready);
      points_sent++;
   endtask

   task automatic drain_results();
      req.valid <= 1'b0;
      while (noise_queue.size() != 0) @(posedge clock);
      repeat (Latency + 4) @(posedge clock);
   endtask

   task automatic write_seed(input logic [15:0] value);
      drain_results();
      csr.we    <= 1'b1;
      csr.wdata <= value;
      @(posedge clock);
      csr.we    <= 1'b0;
      seed_model = value;
   endtask

   // result sink with random stalls while stall_enable is set
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (noise_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected noise word %0d", $signed(rsp.noise_value));
            end else begin
               logic [15:0] want;
               want = noise_queue.pop_front();
               words_checked++;
               if (want !== rsp.noise_value) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("noise mismatch: expected %0d got %0d",
                              $signed(want), $signed(rsp.noise_value));
               end
            end
         end
         rsp.ready <= stall_enable ? ($urandom_range(0, 3) != 0) : 1'b1;
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready) || csr.we)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("watchdog: no progress for %0d cycles", IdleLimit);
         $display("simulation failed");
         $finish;
      end
   end

   // --- tests ---
   task automatic test_reset_seed();
      send_point(32'h0001_8000, 32'h0002_4000, 1'b0);
      send_point(32'h0000_0000, 32'h0000_0000, 1'b0);
   endtask

   task automatic test_field_extremes();
      logic [31:0] edges[6];
      edges = '{32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_FFFF,
                32'h0001_0000, 32'hFFFF_0001};
      foreach (edges[i]) send_point(edges[i], edges[(i + 3) % 6], 1'b1);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      send_point(32'h8000_0000, 32'h8000_0000, 1'b0);
   endtask

   task automatic test_zero_seed();
      write_seed(16'h0000);
      send_point(32'h0000_8000, 32'h0000_8000, 1'b0);
      send_point(32'hFFFF_C000, 32'h0003_2000, 1'b0);
      send_point(32'h1234_5678, 32'h9ABC_DEF0, 1'b0);
   endtask

   task automatic test_max_seed();
      write_seed(16'hFFFF);
      send_point(32'h0000_8000, 32'h0000_8000, 1'b0);
      send_point(32'hDEAD_BEEF, 32'h0BAD_F00D, 1'b0);
   endtask

   task automatic test_random_points(input int count);
      repeat (count) begin
         logic [31:0] px;
         logic [31:0] py;
         px = $urandom();
         py = $urandom();
         // mostly small coordinates, where texture sampling normally lives
         if ($urandom_range(0, 3) != 0) begin
            px = {{12{px[31]}}, px[19:0]};
            py = {{12{py[31]}}, py[19:0]};
         end
         send_point(px, py, 1'b1);
      end
   endtask

   initial begin
      reset        = 1'b1;
      req.valid    = 1'b0;
      req.point_x  = '0;
      req.point_y  = '0;
      rsp.ready    = 1'b0;
      csr.we       = 1'b0;
      csr.wdata    = '0;
      seed_model   = SeedReset;
      mismatches   = 0;
      words_checked = 0;
      points_sent  = 0;
      idle_cycles  = 0;
      stall_enable = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_seed();
      test_field_extremes();
      stall_enable = 1'b1;
      test_zero_seed();
      test_max_seed();
      write_seed(16'd255);
      test_random_points(250);
      write_seed(16'($urandom()));
      test_random_points(200);
      stall_enable = 1'b0;
      write_seed(16'($urandom()));
      test_random_points(200);

      drain_results();
      $display("sent %0d points over seeds 0, 255, 65535 and random; checked %0d noise words",
               points_sent, words_checked);
      if (mismatches == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end
endmodule
